>>> rtl/lrupr_pkg.sv
package lrupr_pkg;

    // Fixed field widths
    localparam int PROC_W   = 5;
    localparam int PC_W     = 16;
    localparam int MASK_W   = 32;
    localparam int SHIFT_W  = 4;
    localparam int ACT_W    = 3;
    localparam int PGOUT_W  = 5;
    localparam int TS_W     = 32;

    // Default sizing
    localparam int NUM_PROCS_DEF      = 32;
    localparam int PAGES_PER_PROC_DEF = 32;

    // Reset values
    localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd7;
    localparam logic [TS_W-1:0]    TICK_RST  = 32'd1;
    localparam logic [TS_W-1:0]    TICK_MAX  = 32'hFFFF_FFFF;

    // Result action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE      = 3'd0,
        ACT_PAGE_IN   = 3'd1,
        ACT_EVICT     = 3'd2,
        ACT_NO_VICTIM = 3'd3,
        ACT_RANGE     = 3'd4
    } t_action;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_SEARCH,
        ST_FINISH,
        ST_DONE
    } t_state;

endpackage

>>> rtl/lrupr_in_if.sv
interface lrupr_in_if;
    logic                           valid;
    logic                           ready;
    logic [lrupr_pkg::PROC_W-1:0]   process;
    logic                           active;
    logic [lrupr_pkg::PC_W-1:0]     pc;
    logic [lrupr_pkg::MASK_W-1:0]   resident_mask;
    logic                           frame_free;
    logic                           end_of_tick;

    modport source (
        output valid, process, active, pc, resident_mask, frame_free, end_of_tick,
        input  ready
    );
    modport sink (
        input  valid, process, active, pc, resident_mask, frame_free, end_of_tick,
        output ready
    );
endinterface

>>> rtl/lrupr_out_if.sv
interface lrupr_out_if;
    logic                           valid;
    logic                           ready;
    logic [lrupr_pkg::ACT_W-1:0]    action;
    logic [lrupr_pkg::PGOUT_W-1:0]  requested_page;
    logic [lrupr_pkg::PGOUT_W-1:0]  evict_page;

    modport source (
        output valid, action, requested_page, evict_page,
        input  ready
    );
    modport sink (
        input  valid, action, requested_page, evict_page,
        output ready
    );
endinterface

>>> rtl/lru_page_replacement_top.sv
// The eviction search reads one timestamp per cycle through the single RAM read port
//   and one comparator, over min(PAGES_PER_PROC, 32) pages. A new item is accepted
//   only in the idle state, after the result of the previous one has been loaded.
// Reset: synchronous active low; then a clearing pass over every RAM address, NUM_PROCS
//   rounded up to a power of two times PAGES_PER_PROC rounded likewise (1024 by default),
//   zeroes the timestamps, input not ready meanwhile; tick resets to 1, page_shift to 7.
module lru_page_replacement_top #(
    parameter int NUM_PROCS      = lrupr_pkg::NUM_PROCS_DEF,
    parameter int PAGES_PER_PROC = lrupr_pkg::PAGES_PER_PROC_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lrupr_pkg::SHIFT_W-1:0]    i_cfg_wdata,
    lrupr_in_if.sink                         i_in,
    lrupr_out_if.source                      o_out
);

    localparam int PROC_IW  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int PAGE_W   = $clog2(PAGES_PER_PROC);
    localparam int MEM_AW   = PROC_IW + PAGE_W;
    localparam int SEARCH_N = (PAGES_PER_PROC < 32) ? PAGES_PER_PROC : 32;
    localparam int MIDX_W   = (PAGE_W < 5) ? PAGE_W : 5;
    localparam logic [PAGE_W-1:0] IDX_LAST = PAGE_W'(SEARCH_N - 1);
    localparam logic [MEM_AW-1:0] CLR_LAST = {MEM_AW{1'b1}};

    lrupr_pkg::t_state r_state, n_state;

    // Config and tick
    logic [lrupr_pkg::SHIFT_W-1:0] r_page_shift;
    logic [lrupr_pkg::TS_W-1:0]    r_tick, n_tick;

    // Latched input item
    logic [lrupr_pkg::PROC_W-1:0]  r_process;
    logic                          r_active;
    logic [lrupr_pkg::PC_W-1:0]    r_pc;
    logic [lrupr_pkg::MASK_W-1:0]  r_mask;
    logic                          r_frame_free;
    logic                          r_end_of_tick;

    // Work registers
    logic [MEM_AW-1:0]             r_clr_addr, n_clr_addr;
    lrupr_pkg::t_action            r_action, n_action;
    logic [lrupr_pkg::PGOUT_W-1:0] r_req, n_req;
    logic                          r_search, n_search;
    logic [PAGE_W-1:0]             r_idx, n_idx;
    logic                          r_cmp_valid, n_cmp_valid;
    logic [PAGE_W-1:0]             r_cmp_idx;
    logic                          r_found;
    logic [PAGE_W-1:0]             r_best;
    logic [lrupr_pkg::TS_W-1:0]    r_best_ts;

    // Output register
    logic                          r_out_valid, n_out_valid;
    lrupr_pkg::t_action            r_out_action;
    logic [lrupr_pkg::PGOUT_W-1:0] r_out_req;
    logic [lrupr_pkg::PGOUT_W-1:0] r_out_evict;
    logic                          out_load;

    // RAM port signals
    logic                          mem_we;
    logic [MEM_AW-1:0]             mem_waddr;
    logic [lrupr_pkg::TS_W-1:0]    mem_wdata;
    logic                          mem_re;
    logic [MEM_AW-1:0]             mem_raddr;
    logic [lrupr_pkg::TS_W-1:0]    mem_rdata;

    // Decode of the latched item
    logic [lrupr_pkg::PC_W-1:0]    page;
    logic [PROC_IW-1:0]            proc_idx;
    logic                          proc_ok;
    logic                          page_ok;
    logic                          resident;
    logic                          in_xfer;
    logic                          cand;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign page     = r_pc >> r_page_shift;
    assign proc_idx = PROC_IW'(r_process);
    assign proc_ok  = (9'(r_process) < 9'(NUM_PROCS));
    assign page_ok  = (page < lrupr_pkg::PC_W'(PAGES_PER_PROC));
    assign resident = (page < 16'd32) && r_mask[page[4:0]];

    lrupr_ts_ram #(
        .ADDR_W (MEM_AW)
    ) u_ts_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Sequencer: next state, RAM control, result staging
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_action    = r_action;
        n_req       = r_req;
        n_search    = r_search;
        n_idx       = r_idx;
        n_cmp_valid = 1'b0;
        n_tick      = r_tick;
        out_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = {proc_idx, PAGE_W'(page)};
        mem_wdata   = r_tick;
        mem_re      = 1'b0;
        mem_raddr   = {proc_idx, r_idx};

        unique case (r_state)
            lrupr_pkg::ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    n_state = lrupr_pkg::ST_IDLE;
                end
            end
            lrupr_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = lrupr_pkg::ST_CALC;
                end
            end
            lrupr_pkg::ST_CALC: begin
                n_search = 1'b0;
                n_req    = '0;
                n_idx    = '0;
                n_state  = lrupr_pkg::ST_DONE;
                priority if (!r_active || !proc_ok) begin
                    n_action = lrupr_pkg::ACT_NONE;
                end else if (!page_ok) begin
                    n_action = lrupr_pkg::ACT_RANGE;
                end else begin
                    // touch the current page
                    mem_we = 1'b1;
                    priority if (resident) begin
                        n_action = lrupr_pkg::ACT_NONE;
                    end else if (r_frame_free) begin
                        n_action = lrupr_pkg::ACT_PAGE_IN;
                        n_req    = page[4:0];
                    end else begin
                        n_action = lrupr_pkg::ACT_NO_VICTIM;
                        n_req    = page[4:0];
                        n_search = 1'b1;
                        n_state  = lrupr_pkg::ST_SEARCH;
                    end
                end
            end
            lrupr_pkg::ST_SEARCH: begin
                // one timestamp read per cycle, compared in the cycle after the read
                mem_re      = 1'b1;
                n_cmp_valid = 1'b1;
                n_idx       = r_idx + 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_state = lrupr_pkg::ST_FINISH;
                end
            end
            lrupr_pkg::ST_FINISH: begin
                n_state = lrupr_pkg::ST_DONE;
            end
            lrupr_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    if (r_end_of_tick && (r_tick != lrupr_pkg::TICK_MAX)) begin
                        n_tick = r_tick + 1'b1;
                    end
                    n_state = lrupr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lrupr_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register next valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lrupr_pkg::ST_CLEAR;
            r_clr_addr   <= '0;
            r_tick       <= lrupr_pkg::TICK_RST;
            r_page_shift <= lrupr_pkg::SHIFT_RST;
            r_out_valid  <= 1'b0;
            r_cmp_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
            r_cmp_valid <= n_cmp_valid;
            if (i_cfg_we) begin
                r_page_shift <= i_cfg_wdata;
            end
        end
    end

    // Input capture
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_process     <= i_in.process;
            r_active      <= i_in.active;
            r_pc          <= i_in.pc;
            r_mask        <= i_in.resident_mask;
            r_frame_free  <= i_in.frame_free;
            r_end_of_tick <= i_in.end_of_tick;
        end
    end

    // Work registers
    always_ff @(posedge i_clk) begin
        r_action  <= n_action;
        r_req     <= n_req;
        r_search  <= n_search;
        r_idx     <= n_idx;
        r_cmp_idx <= r_idx;
    end

    // Shared compare unit: oldest resident timestamp, lowest index on ties
    assign cand = r_mask[r_cmp_idx[MIDX_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (r_state == lrupr_pkg::ST_CALC) begin
            r_found   <= 1'b0;
            r_best    <= '0;
            r_best_ts <= '0;
        end else if (r_cmp_valid && cand && (!r_found || (mem_rdata < r_best_ts))) begin
            r_found   <= 1'b1;
            r_best    <= r_cmp_idx;
            r_best_ts <= mem_rdata;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_req <= r_req;
            if (r_search && r_found) begin
                r_out_action <= lrupr_pkg::ACT_EVICT;
                r_out_evict  <= lrupr_pkg::PGOUT_W'(r_best);
            end else begin
                r_out_action <= r_action;
                r_out_evict  <= '0;
            end
        end
    end

    assign i_in.ready           = (r_state == lrupr_pkg::ST_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.action         = r_out_action;
    assign o_out.requested_page = r_out_req;
    assign o_out.evict_page     = r_out_evict;

endmodule

>>> rtl/lrupr_ts_ram.sv
// Timestamp store: one write port, one read port with registered data
module lrupr_ts_ram #(
    parameter int ADDR_W = 10
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ADDR_W-1:0]            i_waddr,
    input  logic [lrupr_pkg::TS_W-1:0]   i_wdata,
    input  logic                         i_re,
    input  logic [ADDR_W-1:0]            i_raddr,
    output logic [lrupr_pkg::TS_W-1:0]   o_rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [lrupr_pkg::TS_W-1:0] r_mem [DEPTH];
    logic [lrupr_pkg::TS_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> verif/lru_page_replacement_top_tb.sv
module lru_page_replacement_top_tb;
    import lrupr_pkg::*;

    localparam int NPROC  = NUM_PROCS_DEF;
    localparam int NPAGES = PAGES_PER_PROC_DEF;

    typedef struct {
        logic [PROC_W-1:0] process;
        logic              active;
        logic [PC_W-1:0]   pc;
        logic [MASK_W-1:0] resident_mask;
        logic              frame_free;
        logic              end_of_tick;
    } proc_entry_t;

    typedef struct {
        t_action            action;
        logic [PGOUT_W-1:0] requested_page;
        logic [PGOUT_W-1:0] evict_page;
    } replacement_t;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we;
    logic [SHIFT_W-1:0] cfg_wdata;

    lrupr_in_if  in_if ();
    lrupr_out_if out_if ();

    lru_page_replacement_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Shadow copy of the block state
    logic [TS_W-1:0]    page_stamp [NPROC][NPAGES];
    logic [TS_W-1:0]    tick_q       = TICK_RST;
    logic [SHIFT_W-1:0] page_shift_q = SHIFT_RST;

    proc_entry_t  entry_q[$];        // entries waiting to be driven
    replacement_t replacement_q[$];  // predicted decisions, oldest first

    int  send_idle_pct  = 0;
    int  sink_stall_pct = 0;
    int  n_queued       = 0;
    int  n_checked      = 0;
    int  n_errors       = 0;
    bit  in_taken       = 1'b0;

    initial begin
        foreach (page_stamp[p, g]) page_stamp[p][g] = '0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Applies one entry to the shadow state and returns the decision it causes
    function automatic replacement_t predict_replacement(input proc_entry_t e);
        replacement_t    r;
        logic [PC_W-1:0] page;
        logic            found;
        logic [TS_W-1:0] oldest;
        r.action         = ACT_NONE;
        r.requested_page = '0;
        r.evict_page     = '0;
        found            = 1'b0;
        oldest           = '0;
        if (e.active && int'(e.process) < NPROC) begin
            page = e.pc >> page_shift_q;
            if (page >= NPAGES) begin
                r.action = ACT_RANGE;
            end else begin
                page_stamp[e.process][page] = tick_q;
                if (!e.resident_mask[page]) begin
                    r.requested_page = page[PGOUT_W-1:0];
                    if (e.frame_free) begin
                        r.action = ACT_PAGE_IN;
                    end else begin
                        // oldest resident page, lowest index wins a tie
                        for (int i = 0; i < NPAGES && i < 32; i++) begin
                            if (e.resident_mask[i] &&
                                (!found || page_stamp[e.process][i] < oldest)) begin
                                found        = 1'b1;
                                oldest       = page_stamp[e.process][i];
                                r.evict_page = PGOUT_W'(i);
                            end
                        end
                        r.action = found ? ACT_EVICT : ACT_NO_VICTIM;
                    end
                end
            end
        end
        if (e.end_of_tick && tick_q != TICK_MAX) tick_q = tick_q + 1;
        return r;
    endfunction

    function automatic proc_entry_t mk_entry(input int proc, input bit act, input int pc,
                                             input logic [MASK_W-1:0] mask, input bit ff,
                                             input bit eot);
        proc_entry_t e;
        e.process       = PROC_W'(proc);
        e.active        = act;
        e.pc            = PC_W'(pc);
        e.resident_mask = mask;
        e.frame_free    = ff;
        e.end_of_tick   = eot;
        return e;
    endfunction

    // Mostly in-range pages on a few hot processes so timestamps build up
    function automatic proc_entry_t rand_entry(input logic [SHIFT_W-1:0] shift);
        proc_entry_t e;
        int          page;
        int          pick;
        e.process = ($urandom_range(99) < 75) ? PROC_W'($urandom_range(3))
                                              : PROC_W'($urandom_range(31));
        e.active  = ($urandom_range(99) < 90);
        if ($urandom_range(99) < 85) begin
            page = $urandom_range(31);
            e.pc = PC_W'((page << shift) | ($urandom & ((1 << shift) - 1)));
        end else begin
            e.pc = PC_W'($urandom);
        end
        page = int'(e.pc >> shift);
        pick = $urandom_range(99);
        if (pick < 10)      e.resident_mask = '0;
        else if (pick < 20) e.resident_mask = '1;
        else if (pick < 50) e.resident_mask = $urandom & $urandom;
        else                e.resident_mask = $urandom;
        if (page < 32 && $urandom_range(99) < 60) e.resident_mask[page] = 1'b0;
        e.frame_free  = ($urandom_range(99) < 35);
        e.end_of_tick = ($urandom_range(99) < 30);
        return e;
    endfunction

    task automatic queue_entry(input proc_entry_t e);
        entry_q.push_back(e);
        n_queued++;
    endtask

    // Driver: input side changes at the falling edge
    always @(negedge i_clk) begin
        proc_entry_t e;
        if (i_rst_n && (!in_if.valid || in_taken)) begin
            if (entry_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                e = entry_q.pop_front();
                in_if.valid         <= 1'b1;
                in_if.process       <= e.process;
                in_if.active        <= e.active;
                in_if.pc            <= e.pc;
                in_if.resident_mask <= e.resident_mask;
                in_if.frame_free    <= e.frame_free;
                in_if.end_of_tick   <= e.end_of_tick;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Monitor: check result transfers, then predict accepted input transfers
    always @(posedge i_clk) begin
        proc_entry_t  e;
        replacement_t exp_r;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                n_checked++;
                if (replacement_q.size() == 0) begin
                    $error("result with nothing pending: action %0d", out_if.action);
                    n_errors++;
                end else begin
                    exp_r = replacement_q.pop_front();
                    if (out_if.action !== exp_r.action) begin
                        $error("action: expected %0d, got %0d", exp_r.action, out_if.action);
                        n_errors++;
                    end
                    if (out_if.requested_page !== exp_r.requested_page) begin
                        $error("requested_page: expected %0d, got %0d",
                               exp_r.requested_page, out_if.requested_page);
                        n_errors++;
                    end
                    if (out_if.evict_page !== exp_r.evict_page) begin
                        $error("evict_page: expected %0d, got %0d",
                               exp_r.evict_page, out_if.evict_page);
                        n_errors++;
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                in_taken        = 1'b1;
                e.process       = in_if.process;
                e.active        = in_if.active;
                e.pc            = in_if.pc;
                e.resident_mask = in_if.resident_mask;
                e.frame_free    = in_if.frame_free;
                e.end_of_tick   = in_if.end_of_tick;
                replacement_q.push_back(predict_replacement(e));
            end
        end
    end

    // Stimulus: directed entries at the reset shift, then random phases
    initial begin
        logic [SHIFT_W-1:0] shifts [7];
        int                 idle_mode [4][2];
        in_if.valid         = 1'b0;
        in_if.process       = '0;
        in_if.active        = 1'b0;
        in_if.pc            = '0;
        in_if.resident_mask = '0;
        in_if.frame_free    = 1'b0;
        in_if.end_of_tick   = 1'b0;
        out_if.ready        = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        shifts    = '{SHIFT_RST, 4'd0, 4'd15, 4'd3, 4'd10, 4'd11, SHIFT_W'($urandom_range(15))};
        idle_mode = '{'{0, 0}, '{63, 0}, '{0, 63}, '{14, 14}};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // inactive, resident, page-in, nothing to evict
        queue_entry(mk_entry(0, 0, 0, 32'h0, 0, 0));
        queue_entry(mk_entry(0, 1, 0, 32'h1, 0, 1));
        queue_entry(mk_entry(0, 1, (5 << 7) | 127, 32'h0, 1, 0));
        queue_entry(mk_entry(0, 1, 3 << 7, 32'h0, 0, 0));
        // age pages 6, 2, 4 of one process, then evict the oldest
        queue_entry(mk_entry(1, 1, 6 << 7, 32'h54, 0, 1));
        queue_entry(mk_entry(1, 1, 2 << 7, 32'h54, 0, 1));
        queue_entry(mk_entry(1, 1, 4 << 7, 32'h54, 0, 1));
        queue_entry(mk_entry(1, 1, 9 << 7, 32'h54, 0, 0));
        queue_entry(mk_entry(1, 1, 6 << 7, 32'h54, 0, 0));
        queue_entry(mk_entry(1, 1, 9 << 7, 32'h54, 0, 0));
        // equal timestamps go to the lower page
        queue_entry(mk_entry(1, 1, 9 << 7, 32'h0000_0C00, 0, 0));
        // field extremes and out-of-range pages
        queue_entry(mk_entry(31, 1, 16'hFFFF, 32'hFFFF_FFFF, 0, 1));
        queue_entry(mk_entry(31, 1, 31 << 7, 32'hFFFF_FFFF, 0, 0));
        queue_entry(mk_entry(31, 1, (31 << 7) | 127, 32'h7FFF_FFFF, 0, 0));
        queue_entry(mk_entry(2, 1, 32 << 7, 32'h0, 1, 0));
        queue_entry(mk_entry(3, 0, 16'hFFFF, 32'hFFFF_FFFF, 1, 1));
        queue_entry(mk_entry(31, 1, 5 << 7, 32'h8000_0001, 0, 0));
        queue_entry(mk_entry(4, 1, 0, 32'h1, 1, 0));

        for (int ph = 0; ph < 7; ph++) begin
            // register writes only with the block drained
            while (n_checked != n_queued) @(negedge i_clk);
            if (ph != 0) begin
                @(negedge i_clk);
                cfg_we    <= 1'b1;
                cfg_wdata <= shifts[ph];
                @(negedge i_clk);
                cfg_we    <= 1'b0;
                page_shift_q = shifts[ph];
            end
            send_idle_pct  = idle_mode[ph % 4][0];
            sink_stall_pct = idle_mode[ph % 4][1];
            for (int k = 0; k < 72; k++) queue_entry(rand_entry(page_shift_q));
        end

        while (n_checked != n_queued) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (replacement_q.size() != 0) begin
            $error("%0d decisions never arrived", replacement_q.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(8 * 400000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
rtl/lrupr_pkg.sv
rtl/lrupr_in_if.sv
rtl/lrupr_out_if.sv
rtl/lrupr_ts_ram.sv
rtl/lru_page_replacement_top.sv
verif/lru_page_replacement_top_tb.sv
